// ===== design/owm_pkg.sv =====
// Shared types and constants for the one-wire bus master.
package owm_pkg;

   localparam int TIMER_BITS_DEF = 10;
   localparam int CFG_W          = 10;
   localparam int CSR_ADDR_W     = 3;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 16;

   localparam logic [CFG_W-1:0] WR_RECOVERY  = 10'd2;
   localparam logic [CFG_W-1:0] RD_RECOVERY  = 10'd5;
   localparam logic [CFG_W-1:0] RD_HOLD      = 10'd5;
   localparam logic [CFG_W-1:0] RD_REST_TIME = 10'd60;

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_RESET_TAIL    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SHORT_LOW     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_LONG_LOW      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_READ_SAMPLE   = 3'd5;

   // Command codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Reset result codes
   localparam logic [1:0] ST_PRESENT  = 2'd0;
   localparam logic [1:0] ST_NO_PRES  = 2'd1;
   localparam logic [1:0] ST_STUCK_LO = 2'd2;

   typedef enum logic [3:0] {
      P_IDLE, P_RST_LOW, P_RST_WAIT, P_RST_TAIL, P_WR_REC, P_WR_LOW,
      P_WR_REST, P_RD_REC, P_RD_LOW, P_RD_WAIT, P_RD_REST
   } phase_type;

   typedef struct packed {
      logic [9:0] reset_low_time;
      logic [9:0] presence_wait_time;
      logic [9:0] reset_tail_time;
      logic [7:0] short_low_time;
      logic [7:0] long_low_time;
      logic [7:0] read_sample_time;
   } cfg_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_data;
      logic       rejected;
   } res_type;

endpackage

// ===== design/owm_seq.sv =====
// Bus sequencer: phase state, tick timer and shift register, one step per item.
module owm_seq #(
   parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [1:0]          op,
   input  logic [7:0]          data_byte,
   input  logic                line_level,
   input  owm_pkg::cfg_type    cfg,
   output owm_pkg::res_type    res
);

   localparam int LW = (TIMER_BITS > owm_pkg::CFG_W) ? TIMER_BITS : owm_pkg::CFG_W;
   localparam logic [LW-1:0] LEN_MAX = LW'((64'd1 << TIMER_BITS) - 64'd1);

   owm_pkg::phase_type  phase_ff, phase_in;
   logic [TIMER_BITS-1:0] tick_ff, tick_in;
   logic [2:0]          bit_ff, bit_in;
   logic [7:0]          shift_ff, shift_in;
   logic [1:0]          status_ff, status_in;
   logic [7:0]          rdata_ff, rdata_in;

   owm_pkg::phase_type  ph;
   logic [LW-1:0]       raw_len, len;
   logic [LW:0]         tick_next;
   logic                one_bit, done, busy, drive, rej;

   always_comb begin
      ph        = phase_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      status_in = status_ff;
      rdata_in  = rdata_ff;
      done      = 1'b0;
      busy      = 1'b0;
      drive     = 1'b0;
      rej       = 1'b0;
      raw_len   = '0;
      len       = '0;
      tick_next = '0;
      one_bit   = 1'b0;

      // A command on an idle tick starts the sequence on that same tick
      if (phase_ff == owm_pkg::P_IDLE) begin
         if (op != owm_pkg::OP_TICK) begin
            tick_in = '0;
            bit_in  = '0;
            unique case (op)
               owm_pkg::OP_RESET: ph = owm_pkg::P_RST_LOW;
               owm_pkg::OP_WRITE: begin
                  ph       = owm_pkg::P_WR_REC;
                  shift_in = data_byte;
               end
               default: begin
                  ph       = owm_pkg::P_RD_REC;
                  shift_in = '0;
               end
            endcase
         end
      end else if (op != owm_pkg::OP_TICK) begin
         rej = 1'b1;
      end

      one_bit = shift_in[0];
      unique case (ph)
         owm_pkg::P_RST_LOW:  raw_len = LW'(cfg.reset_low_time);
         owm_pkg::P_RST_WAIT: raw_len = LW'(cfg.presence_wait_time);
         owm_pkg::P_RST_TAIL: raw_len = LW'(cfg.reset_tail_time);
         owm_pkg::P_WR_REC:   raw_len = LW'(owm_pkg::WR_RECOVERY);
         owm_pkg::P_WR_LOW:   raw_len = one_bit ? LW'(cfg.short_low_time)
                                                : LW'(cfg.long_low_time);
         owm_pkg::P_WR_REST:  raw_len = one_bit ? LW'(cfg.long_low_time)
                                                : LW'(cfg.short_low_time);
         owm_pkg::P_RD_REC:   raw_len = LW'(owm_pkg::RD_RECOVERY);
         owm_pkg::P_RD_LOW:   raw_len = LW'(owm_pkg::RD_HOLD);
         owm_pkg::P_RD_WAIT:  raw_len = LW'(cfg.read_sample_time);
         default:             raw_len = LW'(owm_pkg::RD_REST_TIME);
      endcase
      // zero lasts one tick; too long clamps to the timer range
      if (raw_len == '0)
         len = LW'(1);
      else if (raw_len > LEN_MAX)
         len = LEN_MAX;
      else
         len = raw_len;

      phase_in = ph;
      if (ph != owm_pkg::P_IDLE) begin
         busy  = 1'b1;
         drive = (ph == owm_pkg::P_RST_LOW) || (ph == owm_pkg::P_WR_LOW) ||
                 (ph == owm_pkg::P_RD_LOW);
         tick_next = (LW+1)'(tick_in) + (LW+1)'(1);
         tick_in   = tick_next[TIMER_BITS-1:0];
         if (tick_next >= {1'b0, len}) begin
            tick_in = '0;
            unique case (ph)
               owm_pkg::P_RST_LOW: phase_in = owm_pkg::P_RST_WAIT;
               owm_pkg::P_RST_WAIT: begin
                  if (line_level) begin
                     status_in = owm_pkg::ST_NO_PRES;
                     phase_in  = owm_pkg::P_IDLE;
                     done      = 1'b1;
                  end else begin
                     phase_in = owm_pkg::P_RST_TAIL;
                  end
               end
               owm_pkg::P_RST_TAIL: begin
                  status_in = line_level ? owm_pkg::ST_PRESENT : owm_pkg::ST_STUCK_LO;
                  phase_in  = owm_pkg::P_IDLE;
                  done      = 1'b1;
               end
               owm_pkg::P_WR_REC: phase_in = owm_pkg::P_WR_LOW;
               owm_pkg::P_WR_LOW: phase_in = owm_pkg::P_WR_REST;
               owm_pkg::P_WR_REST: begin
                  shift_in = {1'b0, shift_in[7:1]};
                  if (bit_in == 3'd7) begin
                     phase_in = owm_pkg::P_IDLE;
                     done     = 1'b1;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     phase_in = owm_pkg::P_WR_REC;
                  end
               end
               owm_pkg::P_RD_REC: phase_in = owm_pkg::P_RD_LOW;
               owm_pkg::P_RD_LOW: phase_in = owm_pkg::P_RD_WAIT;
               owm_pkg::P_RD_WAIT: begin
                  shift_in = {line_level, shift_in[7:1]};
                  phase_in = owm_pkg::P_RD_REST;
               end
               owm_pkg::P_RD_REST: begin
                  if (bit_in == 3'd7) begin
                     rdata_in = shift_in;
                     phase_in = owm_pkg::P_IDLE;
                     done     = 1'b1;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     phase_in = owm_pkg::P_RD_REC;
                  end
               end
               default: phase_in = owm_pkg::P_IDLE;
            endcase
         end
      end

      res.drive_low = drive;
      res.busy_res  = busy;
      res.done_res  = done;
      res.status    = status_in;
      res.read_data = rdata_in;
      res.rejected  = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= owm_pkg::P_IDLE;
         tick_ff   <= '0;
         bit_ff    <= '0;
         shift_ff  <= '0;
         status_ff <= '0;
         rdata_ff  <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         status_ff <= status_in;
         rdata_ff  <= rdata_in;
      end
   end

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      res.drive_low |-> res.busy_res) else $error("drive without busy");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      res.done_res |-> res.busy_res) else $error("done without busy");
   a_idle_no_rej: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == owm_pkg::P_IDLE) |-> !res.rejected) else $error("reject while idle");
   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == owm_pkg::P_IDLE) |-> (tick_ff == '0)) else $error("timer left running");

endmodule

// ===== design/owm_out.sv =====
// Result register stage between the sequencer and the rsp channel.
module owm_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [owm_pkg::RSP_DATA_W-1:0] load_data,
   output logic                          space,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [owm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                           valid_ff, valid_in;
   logic [owm_pkg::RSP_DATA_W-1:0] data_ff;

   // room when empty or when the held item leaves this cycle
   assign space    = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load |-> space) else $error("result overwritten");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid) else $error("loaded result not shown");

endmodule

// ===== design/one_wire_bus_master.sv =====
// Top level of the one-wire bus master: csr registers, sequencer, result stage.
//
//  channel | dir | payload                                    | handshake
//  req     | in  | tuser: op; tdata: data_byte, line_level    | req_tvalid/req_tready
//  rsp     | out | tdata: drive_low .. rejected               | rsp_tvalid/rsp_tready
//  csr     | in  | csr_addr, csr_wdata                        | csr_we
//
//  One item per cycle while the result register has space: each accepted item is one bus tick.
//  Its result shows on rsp in the cycle after acceptance, from the result register.
//  req_tready stays high while the result register is empty or being drained.
//  Synchronous reset idles the sequencer and loads the default timing registers.
module one_wire_bus_master #(
   parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [owm_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] data_byte, [8] line_level
   input  logic [1:0]                        req_tuser,   // [1:0] op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status, [12:5] read_data, [13] rejected
   output logic [owm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [owm_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [owm_pkg::CFG_W-1:0]         csr_wdata
);

   owm_pkg::cfg_type cfg_ff;
   owm_pkg::res_type res;
   logic             space, accept;
   logic [owm_pkg::RSP_DATA_W-1:0] res_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time     <= 10'd700;
         cfg_ff.presence_wait_time <= 10'd90;
         cfg_ff.reset_tail_time    <= 10'd700;
         cfg_ff.short_low_time     <= 8'd6;
         cfg_ff.long_low_time      <= 8'd64;
         cfg_ff.read_sample_time   <= 8'd15;
      end else if (csr_we) begin
         unique case (csr_addr)
            owm_pkg::REG_RESET_LOW:     cfg_ff.reset_low_time     <= csr_wdata;
            owm_pkg::REG_PRESENCE_WAIT: cfg_ff.presence_wait_time <= csr_wdata;
            owm_pkg::REG_RESET_TAIL:    cfg_ff.reset_tail_time    <= csr_wdata;
            owm_pkg::REG_SHORT_LOW:     cfg_ff.short_low_time     <= csr_wdata[7:0];
            owm_pkg::REG_LONG_LOW:      cfg_ff.long_low_time      <= csr_wdata[7:0];
            owm_pkg::REG_READ_SAMPLE:   cfg_ff.read_sample_time   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   owm_seq #(.TIMER_BITS(TIMER_BITS)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step_en    (accept),
      .op         (req_tuser),
      .data_byte  (req_tdata[7:0]),
      .line_level (req_tdata[8]),
      .cfg        (cfg_ff),
      .res        (res)
   );

   assign res_data = {2'b00, res.rejected, res.read_data, res.status,
                      res.done_res, res.busy_res, res.drive_low};

   owm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_data  (res_data),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the one-wire bus master: tick stream, csr timing, result stream.
`timescale 1ns / 1ps

module tb_top;

   localparam int QUIET_LIMIT = 1000;
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_PHASES = 2;
   localparam int PHASE_BUDGET = 30;
   localparam int SLOT_TOP = 12;

   typedef enum int {LINE_LOW, LINE_HIGH, LINE_PRESENT, LINE_RANDOM} line_mode_type;

   // Per-tick predictor of the bus sequencer plus the queue of predicted results.
   class tick_scoreboard;
      owm_pkg::cfg_type    timing;
      owm_pkg::phase_type  seq_phase;
      int                  slot_ticks;
      logic [2:0]          bit_pos;
      logic [7:0]          shifter;
      logic [1:0]          reset_status;
      logic [7:0]          read_byte;
      owm_pkg::res_type    tick_results[$];
      int                  errors;
      int                  items;
      int                  checked;
      int                  rejects;
      int                  starts[4];
      int                  outcomes[3];

      function new();
         timing = '{10'd700, 10'd90, 10'd700, 8'd6, 8'd64, 8'd15};
         seq_phase = owm_pkg::P_IDLE;
         slot_ticks = 0;
         bit_pos = '0;
         shifter = '0;
         reset_status = owm_pkg::ST_PRESENT;
         read_byte = '0;
      endfunction

      function void set_reg(logic [owm_pkg::CSR_ADDR_W-1:0] idx,
                            logic [owm_pkg::CFG_W-1:0] val);
         unique case (idx)
            owm_pkg::REG_RESET_LOW:     timing.reset_low_time = val;
            owm_pkg::REG_PRESENCE_WAIT: timing.presence_wait_time = val;
            owm_pkg::REG_RESET_TAIL:    timing.reset_tail_time = val;
            owm_pkg::REG_SHORT_LOW:     timing.short_low_time = val[7:0];
            owm_pkg::REG_LONG_LOW:      timing.long_low_time = val[7:0];
            owm_pkg::REG_READ_SAMPLE:   timing.read_sample_time = val[7:0];
            default: ;
         endcase
      endfunction

      function int slot_len();
         int t;
         unique case (seq_phase)
            owm_pkg::P_RST_LOW:  t = int'(timing.reset_low_time);
            owm_pkg::P_RST_WAIT: t = int'(timing.presence_wait_time);
            owm_pkg::P_RST_TAIL: t = int'(timing.reset_tail_time);
            owm_pkg::P_WR_REC:   t = int'(owm_pkg::WR_RECOVERY);
            owm_pkg::P_WR_LOW:   t = shifter[0] ? int'(timing.short_low_time)
                                                : int'(timing.long_low_time);
            owm_pkg::P_WR_REST:  t = shifter[0] ? int'(timing.long_low_time)
                                                : int'(timing.short_low_time);
            owm_pkg::P_RD_REC:   t = int'(owm_pkg::RD_RECOVERY);
            owm_pkg::P_RD_LOW:   t = int'(owm_pkg::RD_HOLD);
            owm_pkg::P_RD_WAIT:  t = int'(timing.read_sample_time);
            default:             t = int'(owm_pkg::RD_REST_TIME);
         endcase
         // zero lasts one tick, overlong saturates at the timer width
         if (t == 0) t = 1;
         if (t > (1 << owm_pkg::TIMER_BITS_DEF) - 1) t = (1 << owm_pkg::TIMER_BITS_DEF) - 1;
         return t;
      endfunction

      // Leaves the current slot on its last tick; 1 when the command completes.
      function bit end_slot(logic line);
         unique case (seq_phase)
            owm_pkg::P_RST_LOW: seq_phase = owm_pkg::P_RST_WAIT;
            owm_pkg::P_RST_WAIT: begin
               if (line) begin
                  reset_status = owm_pkg::ST_NO_PRES;
                  outcomes[owm_pkg::ST_NO_PRES]++;
                  seq_phase = owm_pkg::P_IDLE;
                  return 1'b1;
               end
               seq_phase = owm_pkg::P_RST_TAIL;
            end
            owm_pkg::P_RST_TAIL: begin
               reset_status = line ? owm_pkg::ST_PRESENT : owm_pkg::ST_STUCK_LO;
               outcomes[reset_status]++;
               seq_phase = owm_pkg::P_IDLE;
               return 1'b1;
            end
            owm_pkg::P_WR_REC: seq_phase = owm_pkg::P_WR_LOW;
            owm_pkg::P_WR_LOW: seq_phase = owm_pkg::P_WR_REST;
            owm_pkg::P_WR_REST: begin
               shifter = shifter >> 1;
               if (bit_pos == 3'd7) begin
                  seq_phase = owm_pkg::P_IDLE;
                  return 1'b1;
               end
               bit_pos++;
               seq_phase = owm_pkg::P_WR_REC;
            end
            owm_pkg::P_RD_REC: seq_phase = owm_pkg::P_RD_LOW;
            owm_pkg::P_RD_LOW: seq_phase = owm_pkg::P_RD_WAIT;
            owm_pkg::P_RD_WAIT: begin
               shifter = {line, shifter[7:1]};
               seq_phase = owm_pkg::P_RD_REST;
            end
            owm_pkg::P_RD_REST: begin
               if (bit_pos == 3'd7) begin
                  read_byte = shifter;
                  seq_phase = owm_pkg::P_IDLE;
                  return 1'b1;
               end
               bit_pos++;
               seq_phase = owm_pkg::P_RD_REC;
            end
            default: seq_phase = owm_pkg::P_IDLE;
         endcase
         return 1'b0;
      endfunction

      function void note_tick(logic [1:0] op, logic [7:0] din, logic line);
         owm_pkg::res_type r;
         r = '0;
         items++;
         if (seq_phase == owm_pkg::P_IDLE) begin
            if (op != owm_pkg::OP_TICK) begin
               starts[op]++;
               slot_ticks = 0;
               bit_pos = '0;
               unique case (op)
                  owm_pkg::OP_RESET: seq_phase = owm_pkg::P_RST_LOW;
                  owm_pkg::OP_WRITE: begin
                     seq_phase = owm_pkg::P_WR_REC;
                     shifter = din;
                  end
                  default: begin
                     seq_phase = owm_pkg::P_RD_REC;
                     shifter = '0;
                  end
               endcase
            end
         end else if (op != owm_pkg::OP_TICK) begin
            r.rejected = 1'b1;
            rejects++;
         end
         if (seq_phase != owm_pkg::P_IDLE) begin
            r.busy_res = 1'b1;
            r.drive_low = (seq_phase == owm_pkg::P_RST_LOW) ||
                          (seq_phase == owm_pkg::P_WR_LOW) ||
                          (seq_phase == owm_pkg::P_RD_LOW);
            slot_ticks++;
            if (slot_ticks >= slot_len()) begin
               slot_ticks = 0;
               r.done_res = end_slot(line);
            end
         end
         r.status = reset_status;
         r.read_data = read_byte;
         tick_results.push_back(r);
      endfunction

      task report(string msg);
         $display("ERROR %0t ns: %s", $time, msg);
         errors++;
      endtask

      task cmp_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("result %0d %s: got %0h, expected %0h", checked, name, got, want));
      endtask

      task check_tick(logic [owm_pkg::RSP_DATA_W-1:0] d);
         owm_pkg::res_type w;
         if (tick_results.size() == 0) begin
            report($sformatf("result %0h arrived with no item outstanding", d));
            return;
         end
         w = tick_results.pop_front();
         cmp_field("drive_low", 8'(d[0]), 8'(w.drive_low));
         cmp_field("busy", 8'(d[1]), 8'(w.busy_res));
         cmp_field("done", 8'(d[2]), 8'(w.done_res));
         cmp_field("status", 8'(d[4:3]), 8'(w.status));
         cmp_field("read_data", d[12:5], w.read_data);
         cmp_field("rejected", 8'(d[13]), 8'(w.rejected));
         checked++;
      endtask
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [owm_pkg::REQ_DATA_W-1:0]   req_tdata;   // [7:0] data_byte, [8] line_level
   logic [1:0]                       req_tuser;   // [1:0] op
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status, [12:5] read_data, [13] rejected
   logic [owm_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_we;
   logic [owm_pkg::CSR_ADDR_W-1:0]   csr_addr;
   logic [owm_pkg::CFG_W-1:0]        csr_wdata;

   tick_scoreboard sb;
   bit req_gaps;
   bit rsp_gaps;
   bit hold_request;
   bit hold_taken;
   int hold_left;
   int quiet;

   one_wire_bus_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side ready, with random gaps and one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (rsp_gaps && $urandom_range(0, 99) < 14) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_tick(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
               $display("Watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   // Offers one item and returns at the edge that accepts it.
   task send_item(input logic [1:0] op, input logic [7:0] din, input line_mode_type mode);
      logic ln;
      @(negedge clock);
      while (req_gaps && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      unique case (mode)
         LINE_LOW:     ln = 1'b0;
         LINE_HIGH:    ln = 1'b1;
         LINE_PRESENT: ln = (sb.seq_phase != owm_pkg::P_RST_WAIT);  // pulse answers the reset
         default:      ln = 1'($urandom_range(0, 1));
      endcase
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, ln, din};
      do @(posedge clock); while (!req_tready);
      sb.note_tick(op, din, ln);
   endtask

   // Starts a command and ticks it to completion; rej_pct of the ticks carry a stray command.
   task run_cmd(input logic [1:0] op, input logic [7:0] din, input line_mode_type mode,
                input int rej_pct);
      logic [1:0] xop;
      send_item(op, din, mode);
      while (sb.seq_phase != owm_pkg::P_IDLE) begin
         xop = ($urandom_range(0, 99) < rej_pct) ? 2'($urandom_range(1, 3))
                                                 : owm_pkg::OP_TICK;
         send_item(xop, 8'($urandom_range(0, 255)), mode);
      end
   endtask

   task drain_items();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.tick_results.size() != 0) @(posedge clock);
   endtask

   task set_reg(input logic [owm_pkg::CSR_ADDR_W-1:0] idx,
                input logic [owm_pkg::CFG_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task set_timing(input logic [9:0] rl, input logic [9:0] pw, input logic [9:0] rt,
                   input logic [7:0] sl, input logic [7:0] ll, input logic [7:0] rs);
      drain_items();
      set_reg(owm_pkg::REG_RESET_LOW, rl);
      set_reg(owm_pkg::REG_PRESENCE_WAIT, pw);
      set_reg(owm_pkg::REG_RESET_TAIL, rt);
      set_reg(owm_pkg::REG_SHORT_LOW, {2'b00, sl});
      set_reg(owm_pkg::REG_LONG_LOW, {2'b00, ll});
      set_reg(owm_pkg::REG_READ_SAMPLE, {2'b00, rs});
   endtask

   // mostly short slots, sometimes zero, the top value or anything up to it
   function automatic logic [9:0] pick_time(int top);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 12) return 10'(top);
      if (r < 17) return 10'($urandom_range(1, top));
      return 10'($urandom_range(1, 4));
   endfunction

   initial begin
      logic [1:0] op;
      line_mode_type mode;
      int start;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = owm_pkg::OP_TICK;
      csr_we = 1'b0;
      csr_addr = owm_pkg::REG_RESET_LOW;
      csr_wdata = '0;
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      hold_request = 1'b0;
      quiet = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all timing registers zero, so every configurable slot lasts one tick
      set_timing('0, '0, '0, '0, '0, '0);
      run_cmd(owm_pkg::OP_RESET, 8'h00, LINE_LOW, 0);
      run_cmd(owm_pkg::OP_RESET, 8'h00, LINE_HIGH, 0);
      // a stray command on every busy tick, the finishing one included
      run_cmd(owm_pkg::OP_WRITE, 8'h3C, LINE_RANDOM, 100);

      // short uneven slots; a read still rests 60 ticks per bit
      set_timing(10'd3, 10'd2, 10'd4, 8'd1, 8'd2, 8'd2);
      run_cmd(owm_pkg::OP_RESET, 8'h00, LINE_PRESENT, 0);
      hold_request = 1'b1;  // receiver backs up while the read keeps offering items
      run_cmd(owm_pkg::OP_READ, 8'h00, LINE_RANDOM, 10);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_timing(pick_time(SLOT_TOP), pick_time(SLOT_TOP), pick_time(SLOT_TOP),
                    pick_time(SLOT_TOP), pick_time(SLOT_TOP), pick_time(SLOT_TOP));
         // one phase runs with no idling on either side
         req_gaps = (ph != 1);
         rsp_gaps = (ph != 1);
         start = sb.items;
         while (sb.items - start < PHASE_BUDGET) begin
            repeat ($urandom_range(0, 3))
               send_item(owm_pkg::OP_TICK, 8'($urandom_range(0, 255)), LINE_RANDOM);
            op = 2'($urandom_range(1, 2));
            if (op == owm_pkg::OP_RESET) mode = line_mode_type'($urandom_range(0, 3));
            else if ($urandom_range(0, 9) == 0) mode = line_mode_type'($urandom_range(0, 1));
            else mode = LINE_RANDOM;
            run_cmd(op, 8'($urandom_range(0, 255)), mode, 6);
         end
      end

      drain_items();
      repeat (20) @(posedge clock);
      if (sb.tick_results.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.tick_results.size()));
      $display("Ran %0d ticks, checked %0d results; started %0d resets, %0d writes, %0d reads",
               sb.items, sb.checked, sb.starts[owm_pkg::OP_RESET],
               sb.starts[owm_pkg::OP_WRITE], sb.starts[owm_pkg::OP_READ]);
      $display("Busy commands turned away: %0d; reset outcomes present/none/stuck: %0d/%0d/%0d",
               sb.rejects, sb.outcomes[owm_pkg::ST_PRESENT], sb.outcomes[owm_pkg::ST_NO_PRES],
               sb.outcomes[owm_pkg::ST_STUCK_LO]);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
